// ===== rtl/core/odd_even_transposition_sorter_top_defines.svh =====
// Assertion macros shared by the sorter RTL.
`ifndef ODD_EVEN_TRANSPOSITION_SORTER_TOP_DEFINES_SVH
`define ODD_EVEN_TRANSPOSITION_SORTER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every clock edge outside reset.
`define OETS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("oets assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define OETS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("oets assertion failed");

`else

`define OETS_ASSERT_IMP(label, ante, cons)
`define OETS_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ===== rtl/core/oets_pkg.sv =====
// Types and constants shared by the odd-even transposition sorter.
package oets_pkg;

  // Width of one stored value.
  localparam int unsigned VALUE_W = 18;

  // One input transaction.
  typedef struct packed {
    logic signed [VALUE_W-1:0] sample_value;
    logic                      is_last;
  } sample_t;

  // One output transaction.
  typedef struct packed {
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      is_last_res;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store_wr;   // store the incoming value if there is room
    logic sort_step;  // run one compare-exchange phase
    logic sort_odd;   // phase parity: 0 even pairs, 1 odd pairs
    logic emit_pop;   // move the smallest value into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic phase_moved;  // the current phase exchanges at least one pair
    logic last_pop;     // exactly one value is left in the store
  } sts_t;

endpackage

// ===== rtl/core/oets_datapath.sv =====
// Element store, compare-exchange network and output register of the sorter.
`include "odd_even_transposition_sorter_top_defines.svh"

module oets_datapath
  import oets_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = 32
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cmd_t    cmd_i,
  input  sample_t sample_i,
  output sts_t    sts_o,
  output result_t res_o
);

  localparam int unsigned CntW = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned IdxW = $clog2(MAX_ELEMENTS);

  logic signed [VALUE_W-1:0] elem_q [MAX_ELEMENTS];
  logic signed [VALUE_W-1:0] elem_d [MAX_ELEMENTS];
  logic [CntW-1:0]           count_q, count_d;
  logic                      full;
  logic                      phase_moved;
  result_t                   res_q;

  assign full = (count_q == CntW'(MAX_ELEMENTS));

  // Next store contents: load, one compare-exchange phase, or shift out.
  always_comb begin
    elem_d      = elem_q;
    count_d     = count_q;
    phase_moved = 1'b0;
    if (cmd_i.store_wr && !full) begin
      elem_d[count_q[IdxW-1:0]] = sample_i.sample_value;
      count_d                   = count_q + CntW'(1);
    end
    // Pairs of one parity are disjoint, so all of them swap in the same cycle.
    if (cmd_i.sort_step) begin
      for (int i = 0; i < int'(MAX_ELEMENTS) - 1; i++) begin
        if ((((i % 2) != 0) == cmd_i.sort_odd) && (CntW'(i + 1) < count_q) &&
            (elem_q[i] > elem_q[i+1])) begin
          elem_d[i]   = elem_q[i+1];
          elem_d[i+1] = elem_q[i];
          phase_moved = 1'b1;
        end
      end
    end
    // The smallest value sits at entry zero; the rest moves down one place.
    if (cmd_i.emit_pop) begin
      for (int i = 0; i < int'(MAX_ELEMENTS) - 1; i++) begin
        elem_d[i] = elem_q[i+1];
      end
      count_d = count_q - CntW'(1);
    end
  end

  // Store contents carry no reset; only entries below the count are read.
  always_ff @(posedge clk_i) begin
    elem_q <= elem_d;
  end

  // Fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Output register, loaded on each pop.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_pop) begin
      res_q.sorted_value <= elem_q[0];
      res_q.is_last_res  <= (count_q == CntW'(1));
    end
  end

  assign sts_o.phase_moved = phase_moved;
  assign sts_o.last_pop    = (count_q == CntW'(1));
  assign res_o             = res_q;

  // The count never passes the store depth.
  `OETS_ASSERT_IMP(a_count_range, 1'b1, count_q <= CntW'(MAX_ELEMENTS))
  // Each pop removes exactly one value.
  `OETS_ASSERT_NXT(a_pop_count, cmd_i.emit_pop, count_q == $past(count_q) - CntW'(1))
  // The values come out in ascending order.
  `OETS_ASSERT_NXT(a_pop_order, cmd_i.emit_pop && !sts_o.last_pop,
                   elem_q[0] >= res_q.sorted_value)

endmodule

// ===== rtl/core/oets_ctrl.sv =====
// Controller state machine of the sorter: load, sort phases, emit.
`include "odd_even_transposition_sorter_top_defines.svh"

module oets_ctrl
  import oets_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_last_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_LOAD = 4'b0001,
    ST_EVEN = 4'b0010,
    ST_ODD  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   moved_q, moved_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  // The output register can take a value when empty or being drained.
  assign slot_free = !out_valid_q || !out_stall_i;

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    moved_d     = moved_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    unique case (state_q)
      ST_LOAD: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.store_wr = 1'b1;
          if (in_last_i) begin
            state_d = ST_EVEN;
          end
        end
      end
      ST_EVEN: begin
        cmd_o.sort_step = 1'b1;
        moved_d         = sts_i.phase_moved;
        state_d         = ST_ODD;
      end
      ST_ODD: begin
        cmd_o.sort_step = 1'b1;
        cmd_o.sort_odd  = 1'b1;
        // A round without any exchange means the run is in order.
        if (moved_q || sts_i.phase_moved) begin
          state_d = ST_EVEN;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd_o.emit_pop = 1'b1;
          out_valid_d    = 1'b1;
          if (sts_i.last_pop) begin
            state_d = ST_LOAD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      moved_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      moved_q     <= moved_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // The final value of a run starts the sort.
  `OETS_ASSERT_NXT(a_last_starts_sort, in_valid_i && !in_stall_o && in_last_i,
                   state_q == ST_EVEN)
  // A quiet round ends sorting.
  `OETS_ASSERT_NXT(a_quiet_round_emits, state_q == ST_ODD && !moved_q && !sts_i.phase_moved,
                   state_q == ST_EMIT)
  // The last pop hands a valid result over and reopens loading.
  `OETS_ASSERT_NXT(a_last_pop_reload, cmd_o.emit_pop && sts_i.last_pop,
                   state_q == ST_LOAD && out_valid_q)
  // Inputs are taken only while loading.
  `OETS_ASSERT_IMP(a_stall_outside_load, state_q != ST_LOAD, in_stall_o)

endmodule

// ===== rtl/core/odd_even_transposition_sorter_top.sv =====
// Top level of the odd-even transposition sorter.
//
//   channel   direction  handshake                 payload
//   in        input      in_valid_i / in_stall_o   sample_t (sample_value, is_last)
//   out       output     out_valid_o / out_stall_i result_t (sorted_value, is_last_res)
//
// Loading takes a value whenever in_valid_i is high; a run of n values is held in a register store.
// Sorting runs in rounds of an even then an odd phase, at most n/2 + 1 rounds,
// rounded up: the last of them is the quiet round that ends the sort.
// Emitting pops a value whenever the output register is empty or out_stall_i is low.
// No input transaction is taken from the last input value until the last result is in
// the output register. Reset clears only the fill count and control; no clearing pass.
module odd_even_transposition_sorter_top
  import oets_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = 32
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  sample_t in_data_i,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_data_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  oets_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_data_i.is_last),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Store and compare-exchange network.
  oets_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .sample_i (in_data_i),
    .sts_o    (sts),
    .res_o    (out_data_o)
  );

endmodule
